// ===== hdl/ipwc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the IR pulse-width capture encoder.
// No dependencies; imported by ipwc_engine and the top level.
package ipwc_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int MAX_RESULTS     = 5;
    localparam int RES_CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int CFG_DATA_W      = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int BYTES_W         = 11;
    localparam int DUR_W           = 16;

    localparam logic [7:0]  MIN_MARK_RST   = 8'd5;
    localparam logic [15:0] SPACE_TO_RST   = 16'd6000;
    localparam logic [15:0] IDLE_PER_RST   = 16'd50000;
    localparam logic [7:0]  IDLE_LIM_RST   = 8'd30;
    localparam logic [9:0]  MAX_BYTES_RST  = 10'd751;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_MARK  = 3'd0,
        REG_SPACE_TO  = 3'd1,
        REG_IDLE_PER  = 3'd2,
        REG_IDLE_LIM  = 3'd3,
        REG_MAX_BYTES = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        PH_STOPPED = 2'd0,
        PH_MARK    = 2'd1,
        PH_SPACE   = 2'd2,
        PH_IDLE    = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        K_DATA     = 2'd0,
        K_DONE     = 2'd1,
        K_TIMEOUT  = 2'd2,
        K_OVERFLOW = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0]  min_mark_ticks;
        logic [15:0] space_timeout;
        logic [15:0] idle_period;
        logic [7:0]  idle_limit;
        logic [9:0]  max_bytes;
    } cfg_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         value;
        logic [BYTES_W-1:0] byte_total;
    } result_t;

endpackage

// ===== hdl/ipwc_engine.sv =====
`timescale 1ns / 1ps
// Capture session state and per-item step logic: one accepted item in,
// up to MAX_RESULTS results out in the same cycle. Depends on ipwc_pkg.
module ipwc_engine import ipwc_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  take,
    input  logic                                  action,
    input  logic                                  rx_level,
    input  cfg_t                                  cfg,
    output result_t [MAX_RESULTS-1:0]             res,
    output logic [RES_CNT_W-1:0]                  res_count
);

    localparam int CMP_W = (COUNT_WIDTH > DUR_W) ? COUNT_WIDTH : DUR_W;

    phase_t                   phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0]   tick_reg, tick_next;
    logic [7:0]               idle_reg, idle_next;
    logic [BYTES_W-1:0]       bytes_reg, bytes_next;

    logic [COUNT_WIDTH-1:0]   tick_inc;
    logic [CMP_W-1:0]         tick_ext;
    logic [DUR_W-1:0]         dur;
    logic                     dur_long;
    logic [RES_CNT_W-1:0]     dur_len;
    logic [BYTES_W-1:0]       bytes_dur;
    logic [BYTES_W-1:0]       max_ext;
    result_t [MAX_RESULTS-1:0] dur_res;
    logic                     idle_over;
    logic [8:0]               idle_inc;
    logic                     idle_exceed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_STOPPED;
            tick_reg  <= '0;
            idle_reg  <= '0;
            bytes_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            idle_reg  <= idle_next;
            bytes_reg <= bytes_next;
        end
    end

    always_comb begin
        tick_inc    = tick_reg + 1'b1;
        tick_ext    = CMP_W'(tick_inc);
        dur         = (tick_ext > CMP_W'(17'h0FFFF)) ? 16'hFFFF : tick_ext[DUR_W-1:0];
        dur_long    = (dur[15:8] != 8'd0);
        dur_len     = dur_long ? RES_CNT_W'(4) : RES_CNT_W'(1);
        bytes_dur   = bytes_reg + BYTES_W'(dur_len);
        max_ext     = BYTES_W'(cfg.max_bytes);
        idle_over   = tick_ext > CMP_W'(cfg.idle_period);
        idle_inc    = {1'b0, idle_reg} + 9'd1;
        idle_exceed = idle_inc > {1'b0, cfg.idle_limit};
        dur_res     = '0;
        if (dur_long) begin
            dur_res[2].value = dur[15:8];
            dur_res[3].value = dur[7:0];
        end else begin
            dur_res[0].value = dur[7:0];
        end
    end

    always_comb begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        idle_next  = idle_reg;
        bytes_next = bytes_reg;
        res        = '0;
        res_count  = '0;
        if (take) begin
            if (action) begin
                phase_next = PH_MARK;
                tick_next  = COUNT_WIDTH'(1);
                idle_next  = '0;
                bytes_next = '0;
            end else if (phase_reg != PH_STOPPED) begin
                tick_next = tick_inc;
                case (phase_reg)
                    PH_MARK, PH_IDLE: begin
                        if (phase_reg == PH_IDLE && !rx_level) begin
                            phase_next = PH_MARK;
                            tick_next  = COUNT_WIDTH'(1);
                        end else if (phase_reg == PH_MARK && !rx_level) begin
                            phase_next = PH_MARK;
                        end else if (phase_reg == PH_MARK
                                     && tick_ext > CMP_W'(cfg.min_mark_ticks)) begin
                            res        = dur_res;
                            res_count  = dur_len;
                            bytes_next = bytes_dur;
                            tick_next  = COUNT_WIDTH'(1);
                            phase_next = PH_SPACE;
                        end else begin
                            phase_next = PH_IDLE;
                            if (idle_over) begin
                                tick_next = '0;
                                if (idle_exceed) begin
                                    phase_next  = PH_STOPPED;
                                    res[0].kind = K_TIMEOUT;
                                    res_count   = RES_CNT_W'(1);
                                end else begin
                                    idle_next = idle_inc[7:0];
                                end
                            end
                        end
                    end
                    PH_SPACE: begin
                        if (rx_level) begin
                            if (tick_ext > CMP_W'(cfg.space_timeout)) begin
                                res[1].kind       = K_DONE;
                                res[1].byte_total = bytes_reg + 1'b1;
                                res_count         = RES_CNT_W'(2);
                                bytes_next        = bytes_reg + 1'b1;
                                phase_next        = PH_STOPPED;
                            end
                        end else if (bytes_reg >= max_ext) begin
                            res[0].kind       = K_OVERFLOW;
                            res[0].byte_total = bytes_reg;
                            res_count         = RES_CNT_W'(1);
                            phase_next        = PH_STOPPED;
                        end else begin
                            res        = dur_res;
                            bytes_next = bytes_dur;
                            idle_next  = '0;
                            if (bytes_dur >= max_ext) begin
                                if (dur_long) begin
                                    res[4].kind       = K_OVERFLOW;
                                    res[4].byte_total = bytes_dur;
                                end else begin
                                    res[1].kind       = K_OVERFLOW;
                                    res[1].byte_total = bytes_dur;
                                end
                                res_count  = dur_len + 1'b1;
                                phase_next = PH_STOPPED;
                            end else begin
                                res_count  = dur_len;
                                phase_next = PH_MARK;
                                tick_next  = COUNT_WIDTH'(1);
                            end
                        end
                    end
                    default: begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

endmodule

// ===== hdl/ir_pulse_width_capture_encoder_top.sv =====
`timescale 1ns / 1ps
// Top level of the IR pulse-width capture encoder: configuration registers
// and result buffer around ipwc_engine. Depends on ipwc_pkg, ipwc_engine.
//
// Usage:
//   Input stream: s_tuser[0] is the action (1 start a capture session,
//   0 one timer tick), s_tdata[0] the receiver level sampled on the tick.
//   Result stream: m_tuser[1:0] is the kind (data, done, timeout, overflow),
//   m_tdata[7:0] the encoded byte, m_tdata[18:8] the byte total on done or
//   overflow, m_tlast marks the final result of one input transfer.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index (0 min mark
//   ticks, 1 space timeout, 2 idle period, 3 idle limit, 4 max bytes); write
//   only while no results are pending.
// Timing:
//   Results of an input transfer appear in the cycle after it, one per cycle
//   while m_tready is high. An input with k results (at most five) holds the
//   buffer until all k have left; a new input is taken once it is empty or as
//   its last result leaves, so draining the result port sets the input rate.
//   When the receiver stalls, results hold and s_tready drops once the last
//   buffered result cannot leave in this cycle.
// Reset: synchronous, active low; capture stopped, buffer empty, registers
//   at their default values. No clearing pass.
module ir_pulse_width_capture_encoder_top import ipwc_pkg::*; #(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [0] rx_level
    input  logic [0:0]            s_tuser,   // [0] action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // [7:0] value, [18:8] byte_total
    output logic [1:0]            m_tuser,   // [1:0] kind
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t                      cfg_reg;
    result_t [MAX_RESULTS-1:0] res;
    logic [RES_CNT_W-1:0]      res_count;
    result_t                   buf_reg [MAX_RESULTS];
    logic [RES_CNT_W-1:0]      cnt_reg;
    logic [RES_CNT_W-1:0]      idx_reg;
    logic [RES_CNT_W-1:0]      idx_inc;
    logic                      s_xfer;
    logic                      m_xfer;
    result_t                   head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_mark_ticks <= MIN_MARK_RST;
            cfg_reg.space_timeout  <= SPACE_TO_RST;
            cfg_reg.idle_period    <= IDLE_PER_RST;
            cfg_reg.idle_limit     <= IDLE_LIM_RST;
            cfg_reg.max_bytes      <= MAX_BYTES_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MIN_MARK:  cfg_reg.min_mark_ticks <= cfg_wdata[7:0];
                REG_SPACE_TO:  cfg_reg.space_timeout  <= cfg_wdata;
                REG_IDLE_PER:  cfg_reg.idle_period    <= cfg_wdata;
                REG_IDLE_LIM:  cfg_reg.idle_limit     <= cfg_wdata[7:0];
                REG_MAX_BYTES: cfg_reg.max_bytes      <= cfg_wdata[9:0];
                default: begin
                end
            endcase
        end
    end

    ipwc_engine #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (s_xfer),
        .action    (s_tuser[0]),
        .rx_level  (s_tdata[0]),
        .cfg       (cfg_reg),
        .res       (res),
        .res_count (res_count)
    );

    assign idx_inc  = idx_reg + 1'b1;
    assign m_tvalid = (idx_reg != cnt_reg);
    assign m_xfer   = m_tvalid && m_tready;
    assign s_tready = !m_tvalid || (m_tready && idx_inc == cnt_reg);
    assign s_xfer   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end else if (s_xfer) begin
            cnt_reg <= res_count;
            idx_reg <= '0;
        end else if (m_xfer) begin
            idx_reg <= idx_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            for (int i = 0; i < MAX_RESULTS; i++) begin
                buf_reg[i] <= res[i];
            end
        end
    end

    always_comb begin
        head    = buf_reg[idx_reg];
        m_tdata = {5'd0, head.byte_total, head.value};
        m_tuser = head.kind;
        m_tlast = (idx_inc == cnt_reg);
    end

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= RES_CNT_W'(MAX_RESULTS) && idx_reg <= cnt_reg)
        else $error("result buffer count out of range");

    a_load_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s_xfer |=> idx_reg == '0)
        else $error("buffer not restarted after input transfer");

    a_last_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_xfer && m_tlast && !s_xfer) |=> !m_tvalid)
        else $error("results remain after last transfer");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while results are stalled");
`endif

endmodule
